### src/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Semaphore task queue package
// Shared widths, function and status codes, count limits and sequencer states.
// ----------------------------------------------------------------------------
package stq_pkg;

   localparam int TASK_COUNT_DEF = 8;
   localparam int SEM_COUNT_DEF  = 8;

   localparam int FUNC_W  = 2;
   localparam int SIDX_W  = 3;
   localparam int TID_W   = 4;
   localparam int STAT_W  = 2;
   localparam int CNT_W   = 5;

   typedef logic [FUNC_W-1:0]       func_type;
   typedef logic [STAT_W-1:0]       status_type;
   typedef logic [TID_W-1:0]        tid_type;
   typedef logic signed [CNT_W-1:0] count_type;

   localparam func_type FUNC_CREATE   = 2'd0;
   localparam func_type FUNC_DISPATCH = 2'd1;
   localparam func_type FUNC_P        = 2'd2;
   localparam func_type FUNC_V        = 2'd3;

   localparam status_type STATUS_OK      = 2'd0;
   localparam status_type STATUS_NO_SLOT = 2'd1;
   localparam status_type STATUS_EMPTY   = 2'd2;

   localparam count_type CNT_MAX   = 5'sd15;
   localparam count_type CNT_MIN   = -5'sd16;
   localparam count_type CNT_RESET = 5'sd1;

   localparam tid_type NULL_TASK = '0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_APPEND,
      ST_WALK,
      ST_LINK_END,
      ST_POP_READY,
      ST_FINISH
   } state_type;

endpackage
`default_nettype wire

### src/stq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one system-call request.
// ----------------------------------------------------------------------------
interface stq_req_if import stq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SIDX_W-1:0]   sem_index;

   modport source (output valid, func, sem_index, input ready);
   modport sink   (input valid, func, sem_index, output ready);
endinterface
`default_nettype wire

### src/stq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one system-call result.
// ----------------------------------------------------------------------------
interface stq_rsp_if import stq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TID_W-1:0]        task_id;
   logic                    blocked;
   logic [STAT_W-1:0]       status;
   logic signed [CNT_W-1:0] sem_count;

   modport source (output valid, task_id, blocked, status, sem_count, input ready);
   modport sink   (input valid, task_id, blocked, status, sem_count, output ready);
endinterface
`default_nettype wire

### src/semaphore_task_queue_manager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Semaphore task queue manager
// Ready queue, per-semaphore wait queues and counts, kept as linked lists in
// one next-link table that a small sequencer walks one node per cycle.
// ----------------------------------------------------------------------------
// Plain P/V and a create with no free slot go from EXEC straight to FINISH; an
// append walks up to TASK_COUNT + 1 nodes, and a blocking P then pops ready.
// One request at a time, taken in IDLE only; the list walk over the single port
// of the next-link table is the longest step. A waiting response holds back only
// the next result, not the next request.
// Reset clears all lists, marks and the current task; counts return to 1.
// ----------------------------------------------------------------------------
module semaphore_task_queue_manager
   import stq_pkg::*;
#(
   parameter int TASK_COUNT = TASK_COUNT_DEF,
   parameter int SEM_COUNT  = SEM_COUNT_DEF
) (
   input  wire        clock,
   input  wire        reset,
   stq_req_if.sink    req_if,
   stq_rsp_if.source  rsp_if
);

   localparam int TIDX_W    = $clog2(TASK_COUNT + 1);
   localparam int SEM_DEPTH = (SEM_COUNT < (1 << SIDX_W)) ? SEM_COUNT : (1 << SIDX_W);
   localparam int SEM_IW    = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;

   // list and semaphore state
   tid_type              next_link_ff [TASK_COUNT+1];
   tid_type              next_link_in [TASK_COUNT+1];
   logic [TASK_COUNT:1]  in_use_ff, in_use_in;
   tid_type              ready_head_ff, ready_head_in;
   tid_type              current_ff, current_in;
   count_type            sem_counter_ff [SEM_DEPTH];
   count_type            sem_counter_in [SEM_DEPTH];
   tid_type              wait_head_ff [SEM_DEPTH];
   tid_type              wait_head_in [SEM_DEPTH];

   // sequencer
   state_type            state_ff, state_in;
   func_type             func_ff, func_in;
   logic [SIDX_W-1:0]    sidx_ff, sidx_in;
   tid_type              ptr_ff, ptr_in;
   logic [TIDX_W-1:0]    steps_ff, steps_in;
   tid_type              app_tid_ff, app_tid_in;
   logic                 app_ready_ff, app_ready_in;

   // result being built
   tid_type              tid_ff, tid_in;
   logic                 blocked_ff, blocked_in;
   status_type           status_ff, status_in;
   count_type            cnt_ff, cnt_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   tid_type              rsp_tid_ff, rsp_tid_in;
   logic                 rsp_blocked_ff, rsp_blocked_in;
   status_type           rsp_status_ff, rsp_status_in;
   count_type            rsp_cnt_ff, rsp_cnt_in;

   // shared link port and helpers
   tid_type              link_raddr;
   tid_type              link_rdata;
   logic                 req_accept;
   logic                 rsp_free;
   logic [SEM_IW-1:0]    sem_idx;
   logic                 sidx_ok;
   count_type            cnt_cur, cnt_dec, cnt_inc;
   logic                 dec_neg, inc_le0;
   tid_type              wait_cur;
   tid_type              app_head;
   tid_type              free_id;
   logic                 walk_more;
   state_type            after_append;

   assign req_accept = req_if.valid && req_if.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_if.ready;

   assign sem_idx  = sidx_ff[SEM_IW-1:0];
   assign sidx_ok  = int'(sidx_ff) < SEM_COUNT;
   assign cnt_cur  = sem_counter_ff[sem_idx];
   assign wait_cur = wait_head_ff[sem_idx];
   assign cnt_dec  = (cnt_cur == CNT_MIN) ? cnt_cur : cnt_cur - 5'sd1;
   assign cnt_inc  = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + 5'sd1;
   assign dec_neg  = cnt_dec[CNT_W-1];
   assign inc_le0  = cnt_inc[CNT_W-1] || (cnt_inc == '0);
   assign app_head = app_ready_ff ? ready_head_ff : wait_cur;

   // lowest unused task id; zero when all are taken
   always_comb begin
      free_id = NULL_TASK;
      for (int i = TASK_COUNT; i >= 1; i--) begin
         if (!in_use_ff[i]) begin
            free_id = TID_W'(i);
         end
      end
   end

   // single read port of the next-link table
   always_comb begin
      unique case (state_ff)
         ST_EXEC:      link_raddr = wait_cur;
         ST_POP_READY: link_raddr = ready_head_ff;
         default:      link_raddr = ptr_ff;
      endcase
   end
   assign link_rdata = next_link_ff[link_raddr[TIDX_W-1:0]];

   assign walk_more    = (link_rdata != NULL_TASK) && (steps_ff < TIDX_W'(TASK_COUNT));
   assign after_append = (func_ff == FUNC_P) ? ST_POP_READY : ST_FINISH;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (func_ff)
               FUNC_CREATE: begin
                  state_in = (free_id == NULL_TASK) ? ST_FINISH : ST_APPEND;
               end
               FUNC_DISPATCH: begin
                  state_in = ST_POP_READY;
               end
               FUNC_P: begin
                  priority if (!sidx_ok || !dec_neg) begin
                     state_in = ST_FINISH;
                  end else if (current_ff != NULL_TASK) begin
                     state_in = ST_APPEND;
                  end else begin
                     state_in = ST_POP_READY;
                  end
               end
               FUNC_V: begin
                  if (sidx_ok && inc_le0 && (wait_cur != NULL_TASK)) begin
                     state_in = ST_APPEND;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            endcase
         end
         ST_APPEND: begin
            state_in = (app_head == NULL_TASK) ? after_append : ST_WALK;
         end
         ST_WALK: begin
            if (!walk_more) begin
               state_in = ST_LINK_END;
            end
         end
         ST_LINK_END: begin
            state_in = after_append;
         end
         ST_POP_READY: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath
   always_comb begin
      next_link_in   = next_link_ff;
      in_use_in      = in_use_ff;
      ready_head_in  = ready_head_ff;
      current_in     = current_ff;
      sem_counter_in = sem_counter_ff;
      wait_head_in   = wait_head_ff;
      func_in        = func_ff;
      sidx_in        = sidx_ff;
      ptr_in         = ptr_ff;
      steps_in       = steps_ff;
      app_tid_in     = app_tid_ff;
      app_ready_in   = app_ready_ff;
      tid_in         = tid_ff;
      blocked_in     = blocked_ff;
      status_in      = status_ff;
      cnt_in         = cnt_ff;
      rsp_tid_in     = rsp_tid_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               func_in    = req_if.func;
               sidx_in    = req_if.sem_index;
               tid_in     = NULL_TASK;
               blocked_in = 1'b0;
               status_in  = STATUS_OK;
               cnt_in     = '0;
            end
         end
         ST_EXEC: begin
            unique case (func_ff)
               FUNC_CREATE: begin
                  if (free_id == NULL_TASK) begin
                     status_in = STATUS_NO_SLOT;
                  end else begin
                     in_use_in[free_id[TIDX_W-1:0]] = 1'b1;
                     tid_in       = free_id;
                     app_tid_in   = free_id;
                     app_ready_in = 1'b1;
                  end
               end
               FUNC_DISPATCH: begin
               end
               FUNC_P: begin
                  if (sidx_ok) begin
                     cnt_in = cnt_dec;
                     sem_counter_in[sem_idx] = cnt_dec;
                     if (dec_neg && (current_ff != NULL_TASK)) begin
                        app_tid_in   = current_ff;
                        app_ready_in = 1'b0;
                        blocked_in   = 1'b1;
                     end
                  end
               end
               FUNC_V: begin
                  if (sidx_ok) begin
                     cnt_in = cnt_inc;
                     sem_counter_in[sem_idx] = cnt_inc;
                     if (inc_le0 && (wait_cur != NULL_TASK)) begin
                        // pop the wait queue, then append to ready
                        tid_in                = wait_cur;
                        wait_head_in[sem_idx] = link_rdata;
                        app_tid_in            = wait_cur;
                        app_ready_in          = 1'b1;
                     end
                  end
               end
            endcase
         end
         ST_APPEND: begin
            if (app_head == NULL_TASK) begin
               if (app_ready_ff) begin
                  ready_head_in = app_tid_ff;
               end else begin
                  wait_head_in[sem_idx] = app_tid_ff;
               end
               next_link_in[app_tid_ff[TIDX_W-1:0]] = NULL_TASK;
            end else begin
               ptr_in   = app_head;
               steps_in = '0;
            end
         end
         ST_WALK: begin
            if (walk_more) begin
               ptr_in   = link_rdata;
               steps_in = steps_ff + 1'b1;
            end else begin
               next_link_in[ptr_ff[TIDX_W-1:0]] = app_tid_ff;
            end
         end
         ST_LINK_END: begin
            // terminate the list at the appended task
            next_link_in[app_tid_ff[TIDX_W-1:0]] = NULL_TASK;
         end
         ST_POP_READY: begin
            tid_in     = ready_head_ff;
            current_in = ready_head_ff;
            if (ready_head_ff != NULL_TASK) begin
               ready_head_in = link_rdata;
            end else begin
               status_in = STATUS_EMPTY;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_tid_in     = tid_ff;
               rsp_blocked_in = blocked_ff;
               rsp_status_in  = status_ff;
               rsp_cnt_in     = cnt_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         in_use_ff     <= '0;
         ready_head_ff <= NULL_TASK;
         current_ff    <= NULL_TASK;
         for (int i = 0; i <= TASK_COUNT; i++) begin
            next_link_ff[i] <= NULL_TASK;
         end
         for (int s = 0; s < SEM_DEPTH; s++) begin
            sem_counter_ff[s] <= CNT_RESET;
            wait_head_ff[s]   <= NULL_TASK;
         end
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         in_use_ff      <= in_use_in;
         ready_head_ff  <= ready_head_in;
         current_ff     <= current_in;
         next_link_ff   <= next_link_in;
         sem_counter_ff <= sem_counter_in;
         wait_head_ff   <= wait_head_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      sidx_ff        <= sidx_in;
      ptr_ff         <= ptr_in;
      steps_ff       <= steps_in;
      app_tid_ff     <= app_tid_in;
      app_ready_ff   <= app_ready_in;
      tid_ff         <= tid_in;
      blocked_ff     <= blocked_in;
      status_ff      <= status_in;
      cnt_ff         <= cnt_in;
      rsp_tid_ff     <= rsp_tid_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_cnt_ff     <= rsp_cnt_in;
   end

   // outputs
   assign req_if.ready     = (state_ff == ST_IDLE);
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.task_id   = rsp_tid_ff;
   assign rsp_if.blocked   = rsp_blocked_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.sem_count = rsp_cnt_ff;

endmodule
`default_nettype wire
